// ===== rtl/tdsc_pkg.sv =====
`default_nettype none

package tdsc_pkg;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_SCALE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SERVO_STEP  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_SMOOTH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_NORMAL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_AGGR   = 3'd4;

    localparam logic [7:0] RST_TURN_SCALE  = 8'd100;
    localparam logic [7:0] RST_SERVO_STEP  = 8'd4;
    localparam logic [7:0] RST_RAMP_SMOOTH = 8'd2;
    localparam logic [7:0] RST_RAMP_NORMAL = 8'd6;
    localparam logic [7:0] RST_RAMP_AGGR   = 8'd25;

    // Direction codes.
    localparam logic [3:0] DIR_HALT   = 4'd0;
    localparam logic [3:0] DIR_FWD    = 4'd1;
    localparam logic [3:0] DIR_BWD    = 4'd2;
    localparam logic [3:0] DIR_SPIN_L = 4'd3;
    localparam logic [3:0] DIR_SPIN_R = 4'd4;
    localparam logic [3:0] DIR_ARC_FL = 4'd5;
    localparam logic [3:0] DIR_ARC_FR = 4'd6;
    localparam logic [3:0] DIR_ARC_BL = 4'd7;
    localparam logic [3:0] DIR_ARC_BR = 4'd8;

    // Ramp profile codes.
    localparam logic [1:0] PROF_SMOOTH = 2'd0;
    localparam logic [1:0] PROF_NORMAL = 2'd1;
    localparam logic [1:0] PROF_AGGR   = 2'd2;

    localparam int SPEED_LIM      = 100;
    localparam int TURN_MIN       = 30;
    localparam int TURN_MAX       = 100;
    localparam int ANGLE_MAX      = 180;
    localparam int ANGLE_RESET    = 90;
    localparam int DUTY_FULL      = 255;
    localparam int SERVO_BASE_US  = 500;
    localparam int SERVO_SPAN_US  = 2000;

    // floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for every x below 2^15.
    localparam int RECIP_100   = 5243;
    localparam int RECIP_SHIFT = 19;

    typedef struct packed {
        logic [7:0] turn_scale;
        logic [7:0] servo_step;
        logic [7:0] ramp_smooth;
        logic [7:0] ramp_normal;
        logic [7:0] ramp_aggr;
    } t_cfg;

    typedef struct packed {
        logic              powered;
        logic              fault;
        logic [3:0]        direction;
        logic [6:0]        speed_pct;
        logic [1:0]        profile;
        logic              direct_mode;
        logic signed [7:0] direct_left;
        logic signed [7:0] direct_right;
        logic [7:0]        left_arm_target;
        logic [7:0]        right_arm_target;
    } t_cmd;

    typedef struct packed {
        logic              run;
        logic signed [7:0] left_tgt;
        logic signed [7:0] right_tgt;
        logic [7:0]        ramp_step;
        logic [7:0]        left_arm;
        logic [7:0]        right_arm;
    } t_tgt;

    typedef logic [SPEED_LIM:0][7:0]  t_duty_tab;
    typedef logic [ANGLE_MAX:0][11:0] t_servo_tab;

    function automatic t_duty_tab f_duty_tab();
        t_duty_tab tab;
        for (int i = 0; i <= SPEED_LIM; i++) begin
            tab[i] = 8'(i * DUTY_FULL / SPEED_LIM);
        end
        return tab;
    endfunction

    function automatic t_servo_tab f_servo_tab();
        t_servo_tab tab;
        for (int i = 0; i <= ANGLE_MAX; i++) begin
            tab[i] = 12'(SERVO_BASE_US + i * SERVO_SPAN_US / ANGLE_MAX);
        end
        return tab;
    endfunction

    localparam t_duty_tab  DUTY_TAB  = f_duty_tab();
    localparam t_servo_tab SERVO_TAB = f_servo_tab();

    // Moves cur towards goal by at most step.
    function automatic logic signed [9:0] f_slew(input logic signed [9:0] cur,
                                                 input logic signed [9:0] goal,
                                                 input logic [7:0] step);
        logic signed [10:0] diff;
        logic signed [10:0] st;
        logic signed [10:0] res;
        diff = 11'(goal) - 11'(cur);
        st   = signed'({3'b000, step});
        if (diff > st) begin
            res = 11'(cur) + st;
        end else if (diff < -st) begin
            res = 11'(cur) - st;
        end else begin
            res = 11'(goal);
        end
        return res[9:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/tdsc_cfg.sv =====
`default_nettype none

module tdsc_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    input  wire logic [tdsc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [7:0]                     i_cfg_data,
    output tdsc_pkg::t_cfg                      o_cfg
);
    import tdsc_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.turn_scale  <= RST_TURN_SCALE;
            r_cfg.servo_step  <= RST_SERVO_STEP;
            r_cfg.ramp_smooth <= RST_RAMP_SMOOTH;
            r_cfg.ramp_normal <= RST_RAMP_NORMAL;
            r_cfg.ramp_aggr   <= RST_RAMP_AGGR;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TURN_SCALE:  r_cfg.turn_scale  <= i_cfg_data;
                CFG_SERVO_STEP:  r_cfg.servo_step  <= i_cfg_data;
                CFG_RAMP_SMOOTH: r_cfg.ramp_smooth <= i_cfg_data;
                CFG_RAMP_NORMAL: r_cfg.ramp_normal <= i_cfg_data;
                CFG_RAMP_AGGR:   r_cfg.ramp_aggr   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== rtl/tdsc_target.sv =====
`default_nettype none

module tdsc_target (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    input  wire tdsc_pkg::t_cmd i_cmd,
    input  wire tdsc_pkg::t_cfg i_cfg,
    output logic           o_ready,
    output logic           o_valid,
    output tdsc_pkg::t_tgt o_tgt,
    input  wire logic      i_ready
);
    import tdsc_pkg::*;

    function automatic logic signed [7:0] f_sat_pct(input logic signed [7:0] v);
        logic signed [7:0] res;
        if (v < -8'sd100) begin
            res = -8'sd100;
        end else if (v > 8'sd100) begin
            res = 8'sd100;
        end else begin
            res = v;
        end
        return res;
    endfunction

    // Stage one: turn product.
    logic        r_s1_valid;
    t_cmd        r_s1_cmd;
    logic [14:0] r_s1_prod;
    // Stage two: side targets and steps.
    logic        r_s2_valid;
    t_tgt        r_s2_tgt;

    logic        w_s2_take;
    logic        w_s1_take;
    logic [14:0] w_prod;
    logic [27:0] w_quot_full;
    logic [8:0]  w_quot;
    logic [6:0]  w_turn;
    logic [6:0]  w_spd;
    logic [6:0]  w_half;
    logic signed [7:0] w_lt;
    logic signed [7:0] w_rt;
    t_tgt        n_s2_tgt;

    assign w_s2_take = !r_s2_valid || i_ready;
    assign w_s1_take = !r_s1_valid || w_s2_take;
    assign o_ready   = w_s1_take;
    assign o_valid   = r_s2_valid;
    assign o_tgt     = r_s2_tgt;

    assign w_prod = {8'b0, i_cmd.speed_pct} * {7'b0, i_cfg.turn_scale};

    always_comb begin
        w_quot_full = {13'b0, r_s1_prod} * 28'(RECIP_100);
        w_quot      = 9'(w_quot_full >> RECIP_SHIFT);
        if (w_quot < 9'(TURN_MIN)) begin
            w_turn = 7'(TURN_MIN);
        end else if (w_quot > 9'(TURN_MAX)) begin
            w_turn = 7'(TURN_MAX);
        end else begin
            w_turn = w_quot[6:0];
        end
        w_spd  = (r_s1_cmd.speed_pct > 7'(SPEED_LIM)) ? 7'(SPEED_LIM)
                                                       : r_s1_cmd.speed_pct;
        w_half = r_s1_cmd.speed_pct >> 1;

        w_lt = '0;
        w_rt = '0;
        if (r_s1_cmd.direct_mode) begin
            w_lt = f_sat_pct(r_s1_cmd.direct_left);
            w_rt = f_sat_pct(r_s1_cmd.direct_right);
        end else begin
            case (r_s1_cmd.direction)
                DIR_FWD: begin
                    w_lt = signed'({1'b0, w_spd});
                    w_rt = signed'({1'b0, w_spd});
                end
                DIR_BWD: begin
                    w_lt = -signed'({1'b0, w_spd});
                    w_rt = -signed'({1'b0, w_spd});
                end
                DIR_SPIN_L: begin
                    w_lt = -signed'({1'b0, w_turn});
                    w_rt = signed'({1'b0, w_turn});
                end
                DIR_SPIN_R: begin
                    w_lt = signed'({1'b0, w_turn});
                    w_rt = -signed'({1'b0, w_turn});
                end
                DIR_ARC_FL: begin
                    w_lt = signed'({1'b0, w_half});
                    w_rt = signed'({1'b0, w_spd});
                end
                DIR_ARC_FR: begin
                    w_lt = signed'({1'b0, w_spd});
                    w_rt = signed'({1'b0, w_half});
                end
                DIR_ARC_BL: begin
                    w_lt = -signed'({1'b0, w_half});
                    w_rt = -signed'({1'b0, w_spd});
                end
                DIR_ARC_BR: begin
                    w_lt = -signed'({1'b0, w_spd});
                    w_rt = -signed'({1'b0, w_half});
                end
                default: begin
                    w_lt = '0;
                    w_rt = '0;
                end
            endcase
        end

        n_s2_tgt.run       = r_s1_cmd.powered && !r_s1_cmd.fault;
        n_s2_tgt.left_tgt  = n_s2_tgt.run ? w_lt : '0;
        n_s2_tgt.right_tgt = n_s2_tgt.run ? w_rt : '0;
        case (r_s1_cmd.profile)
            PROF_SMOOTH: n_s2_tgt.ramp_step = i_cfg.ramp_smooth;
            PROF_NORMAL: n_s2_tgt.ramp_step = i_cfg.ramp_normal;
            PROF_AGGR:   n_s2_tgt.ramp_step = i_cfg.ramp_aggr;
            default:     n_s2_tgt.ramp_step = i_cfg.ramp_aggr;
        endcase
        n_s2_tgt.left_arm  = (r_s1_cmd.left_arm_target > 8'(ANGLE_MAX)) ?
                             8'(ANGLE_MAX) : r_s1_cmd.left_arm_target;
        n_s2_tgt.right_arm = (r_s1_cmd.right_arm_target > 8'(ANGLE_MAX)) ?
                             8'(ANGLE_MAX) : r_s1_cmd.right_arm_target;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (w_s1_take) begin
                r_s1_valid <= i_valid;
            end
            if (w_s2_take) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_take && i_valid) begin
            r_s1_cmd  <= i_cmd;
            r_s1_prod <= w_prod;
        end
        if (w_s2_take && r_s1_valid) begin
            r_s2_tgt <= n_s2_tgt;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tdsc_slew.sv =====
`default_nettype none

module tdsc_slew (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire tdsc_pkg::t_tgt i_tgt,
    input  wire logic [7:0]  i_servo_step,
    output logic             o_ready,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_left_fwd_duty,
    output logic [7:0]       o_left_bwd_duty,
    output logic [7:0]       o_right_fwd_duty,
    output logic [7:0]       o_right_bwd_duty,
    output logic [11:0]      o_left_servo_us,
    output logic [11:0]      o_right_servo_us,
    output logic signed [7:0] o_left_speed_now,
    output logic signed [7:0] o_right_speed_now
);
    import tdsc_pkg::*;

    logic signed [7:0] r_left_act;
    logic signed [7:0] r_right_act;
    logic [7:0]        r_left_ang;
    logic [7:0]        r_right_ang;
    logic              r_out_valid;

    logic signed [7:0] n_left_act;
    logic signed [7:0] n_right_act;
    logic [7:0]        n_left_ang;
    logic [7:0]        n_right_ang;
    logic [9:0]        w_left_ang;
    logic [9:0]        w_right_ang;
    logic [7:0]        w_left_mag;
    logic [7:0]        w_right_mag;
    logic              w_load;

    assign o_ready     = !r_out_valid || i_out_ready;
    assign w_load      = i_valid && o_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        if (i_tgt.run) begin
            n_left_act  = 8'(f_slew(10'(r_left_act), 10'(i_tgt.left_tgt),
                                    i_tgt.ramp_step));
            n_right_act = 8'(f_slew(10'(r_right_act), 10'(i_tgt.right_tgt),
                                    i_tgt.ramp_step));
            w_left_ang  = f_slew(signed'({2'b00, r_left_ang}),
                                 signed'({2'b00, i_tgt.left_arm}), i_servo_step);
            w_right_ang = f_slew(signed'({2'b00, r_right_ang}),
                                 signed'({2'b00, i_tgt.right_arm}), i_servo_step);
            n_left_ang  = w_left_ang[7:0];
            n_right_ang = w_right_ang[7:0];
        end else begin
            // Power off or fault stops both sides at once and holds the arms still.
            n_left_act  = '0;
            n_right_act = '0;
            w_left_ang  = '0;
            w_right_ang = '0;
            n_left_ang  = r_left_ang;
            n_right_ang = r_right_ang;
        end
        w_left_mag  = (n_left_act < 0) ? 8'(-n_left_act) : 8'(n_left_act);
        w_right_mag = (n_right_act < 0) ? 8'(-n_right_act) : 8'(n_right_act);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_act  <= '0;
            r_right_act <= '0;
            r_left_ang  <= 8'(ANGLE_RESET);
            r_right_ang <= 8'(ANGLE_RESET);
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_out_valid <= i_valid;
            end
            if (w_load) begin
                r_left_act  <= n_left_act;
                r_right_act <= n_right_act;
                r_left_ang  <= n_left_ang;
                r_right_ang <= n_right_ang;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            o_left_fwd_duty   <= (n_left_act > 0) ? DUTY_TAB[w_left_mag[6:0]] : '0;
            o_left_bwd_duty   <= (n_left_act < 0) ? DUTY_TAB[w_left_mag[6:0]] : '0;
            o_right_fwd_duty  <= (n_right_act > 0) ? DUTY_TAB[w_right_mag[6:0]] : '0;
            o_right_bwd_duty  <= (n_right_act < 0) ? DUTY_TAB[w_right_mag[6:0]] : '0;
            o_left_servo_us   <= SERVO_TAB[n_left_ang];
            o_right_servo_us  <= SERVO_TAB[n_right_ang];
            o_left_speed_now  <= n_left_act;
            o_right_speed_now <= n_right_act;
        end
    end

    a_speed_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left_act >= -SPEED_LIM && r_left_act <= SPEED_LIM &&
        r_right_act >= -SPEED_LIM && r_right_act <= SPEED_LIM)
        else $error("side speed out of range");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left_ang <= 8'(ANGLE_MAX) && r_right_ang <= 8'(ANGLE_MAX))
        else $error("arm angle out of range");

    a_stop_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && !i_tgt.run) |=> (r_left_act == 0 && r_right_act == 0 &&
                                    o_left_fwd_duty == 0 && o_right_bwd_duty == 0))
        else $error("stopped item left a side moving");

    a_arms_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && !i_tgt.run) |=> ($stable(r_left_ang) && $stable(r_right_ang)))
        else $error("arms moved without power");

    a_state_only_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_load |=> ($stable(r_left_act) && $stable(r_right_act)))
        else $error("side speed changed without an item");

endmodule

`default_nettype wire

// ===== rtl/tank_drive_slew_controller_core.sv =====
`default_nettype none

// Throughput: one item per cycle while the result is taken; four register stages
// (input, turn product, side targets, slew state and result) each pass an item on
// every cycle that the next stage can take it.
// A stalled result holds the pipeline back stage by stage, never drops an item.
// Reset (synchronous, active low) empties the pipeline, sets both side speeds
// to zero, both arm angles to 90 degrees and the configuration registers to their defaults.
module tank_drive_slew_controller_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [tdsc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [7:0]                     i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic                           i_powered,
    input  wire logic                           i_fault,
    input  wire logic [3:0]                     i_direction,
    input  wire logic [6:0]                     i_speed_pct,
    input  wire logic [1:0]                     i_profile,
    input  wire logic                           i_direct_mode,
    input  wire logic signed [7:0]              i_direct_left,
    input  wire logic signed [7:0]              i_direct_right,
    input  wire logic [7:0]                     i_left_arm_target,
    input  wire logic [7:0]                     i_right_arm_target,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic [7:0]                          o_left_fwd_duty,
    output logic [7:0]                          o_left_bwd_duty,
    output logic [7:0]                          o_right_fwd_duty,
    output logic [7:0]                          o_right_bwd_duty,
    output logic [11:0]                         o_left_servo_us,
    output logic [11:0]                         o_right_servo_us,
    output logic signed [7:0]                   o_left_speed_now,
    output logic signed [7:0]                   o_right_speed_now
);
    import tdsc_pkg::*;

    t_cfg w_cfg;
    t_cmd r_in_cmd;
    logic r_in_valid;
    logic w_tgt_ready;
    logic w_tgt_valid;
    t_tgt w_tgt;
    logic w_slew_ready;
    logic w_in_take;

    assign o_cfg_ready = 1'b1;
    assign w_in_take   = !r_in_valid || w_tgt_ready;
    assign o_in_ready  = w_in_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take && i_in_valid) begin
            r_in_cmd.powered          <= i_powered;
            r_in_cmd.fault            <= i_fault;
            r_in_cmd.direction        <= i_direction;
            r_in_cmd.speed_pct        <= i_speed_pct;
            r_in_cmd.profile          <= i_profile;
            r_in_cmd.direct_mode      <= i_direct_mode;
            r_in_cmd.direct_left      <= i_direct_left;
            r_in_cmd.direct_right     <= i_direct_right;
            r_in_cmd.left_arm_target  <= i_left_arm_target;
            r_in_cmd.right_arm_target <= i_right_arm_target;
        end
    end

    tdsc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    tdsc_target u_target (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid),
        .i_cmd   (r_in_cmd),
        .i_cfg   (w_cfg),
        .o_ready (w_tgt_ready),
        .o_valid (w_tgt_valid),
        .o_tgt   (w_tgt),
        .i_ready (w_slew_ready)
    );

    tdsc_slew u_slew (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (w_tgt_valid),
        .i_tgt             (w_tgt),
        .i_servo_step      (w_cfg.servo_step),
        .o_ready           (w_slew_ready),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_left_fwd_duty   (o_left_fwd_duty),
        .o_left_bwd_duty   (o_left_bwd_duty),
        .o_right_fwd_duty  (o_right_fwd_duty),
        .o_right_bwd_duty  (o_right_bwd_duty),
        .o_left_servo_us   (o_left_servo_us),
        .o_right_servo_us  (o_right_servo_us),
        .o_left_speed_now  (o_left_speed_now),
        .o_right_speed_now (o_right_speed_now)
    );

endmodule

`default_nettype wire

// ===== tb/sv/tank_drive_slew_controller_core_test.sv =====
`default_nettype none

module tank_drive_slew_controller_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tdsc_pkg::*;

    typedef struct packed {
        logic [7:0]        lf_duty;
        logic [7:0]        lb_duty;
        logic [7:0]        rf_duty;
        logic [7:0]        rb_duty;
        logic [11:0]       left_us;
        logic [11:0]       right_us;
        logic signed [7:0] left_now;
        logic signed [7:0] right_now;
    } t_drive_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [7:0]           i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic                 i_powered = 1'b0;
    logic                 i_fault = 1'b0;
    logic [3:0]           i_direction = '0;
    logic [6:0]           i_speed_pct = '0;
    logic [1:0]           i_profile = '0;
    logic                 i_direct_mode = 1'b0;
    logic signed [7:0]    i_direct_left = '0;
    logic signed [7:0]    i_direct_right = '0;
    logic [7:0]           i_left_arm_target = '0;
    logic [7:0]           i_right_arm_target = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [7:0]           o_left_fwd_duty;
    logic [7:0]           o_left_bwd_duty;
    logic [7:0]           o_right_fwd_duty;
    logic [7:0]           o_right_bwd_duty;
    logic [11:0]          o_left_servo_us;
    logic [11:0]          o_right_servo_us;
    logic signed [7:0]    o_left_speed_now;
    logic signed [7:0]    o_right_speed_now;

    tank_drive_slew_controller_core DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_powered          (i_powered),
        .i_fault            (i_fault),
        .i_direction        (i_direction),
        .i_speed_pct        (i_speed_pct),
        .i_profile          (i_profile),
        .i_direct_mode      (i_direct_mode),
        .i_direct_left      (i_direct_left),
        .i_direct_right     (i_direct_right),
        .i_left_arm_target  (i_left_arm_target),
        .i_right_arm_target (i_right_arm_target),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_left_fwd_duty    (o_left_fwd_duty),
        .o_left_bwd_duty    (o_left_bwd_duty),
        .o_right_fwd_duty   (o_right_fwd_duty),
        .o_right_bwd_duty   (o_right_bwd_duty),
        .o_left_servo_us    (o_left_servo_us),
        .o_right_servo_us   (o_right_servo_us),
        .o_left_speed_now   (o_left_speed_now),
        .o_right_speed_now  (o_right_speed_now)
    );

    // Register copies and drive state tracked alongside the block.
    logic [7:0] turn_scale = RST_TURN_SCALE;
    logic [7:0] servo_step = RST_SERVO_STEP;
    logic [7:0] step_smooth = RST_RAMP_SMOOTH;
    logic [7:0] step_normal = RST_RAMP_NORMAL;
    logic [7:0] step_aggr = RST_RAMP_AGGR;
    int left_speed = 0;
    int right_speed = 0;
    int left_angle = ANGLE_RESET;
    int right_angle = ANGLE_RESET;

    t_cmd          tick_queue[$];
    t_drive_result drive_outputs_q[$];
    t_cmd          held_tick;
    int            send_idle_pct = 0;
    int            stall_pct = 0;
    int            error_count = 0;

    function automatic int bound(int v, int lo, int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int approach(int cur, int goal, int step);
        if (cur < goal) return cur + ((goal - cur < step) ? goal - cur : step);
        if (cur > goal) return cur - ((cur - goal < step) ? cur - goal : step);
        return cur;
    endfunction

    // Forward duty in the upper byte, backward duty in the lower one.
    function automatic logic [15:0] duty_pair(int pct);
        logic [7:0] mag;
        mag = 8'(((pct < 0) ? -pct : pct) * DUTY_FULL / SPEED_LIM);
        return {(pct > 0) ? mag : 8'd0, (pct < 0) ? mag : 8'd0};
    endfunction

    function automatic t_drive_result advance_drive(t_cmd c);
        t_drive_result r;
        int spd;
        int turn;
        int lt;
        int rt;
        int ramp;
        spd = int'(c.speed_pct);
        lt = 0;
        rt = 0;
        if (c.direct_mode) begin
            lt = int'($signed(c.direct_left));
            rt = int'($signed(c.direct_right));
        end else begin
            turn = bound(spd * int'(turn_scale) / 100, TURN_MIN, TURN_MAX);
            case (c.direction)
                DIR_FWD: begin lt = spd; rt = spd; end
                DIR_BWD: begin lt = -spd; rt = -spd; end
                DIR_SPIN_L: begin lt = -turn; rt = turn; end
                DIR_SPIN_R: begin lt = turn; rt = -turn; end
                DIR_ARC_FL: begin lt = spd / 2; rt = spd; end
                DIR_ARC_FR: begin lt = spd; rt = spd / 2; end
                DIR_ARC_BL: begin lt = -(spd / 2); rt = -spd; end
                DIR_ARC_BR: begin lt = -spd; rt = -(spd / 2); end
                default: begin lt = 0; rt = 0; end
            endcase
        end
        lt = bound(lt, -SPEED_LIM, SPEED_LIM);
        rt = bound(rt, -SPEED_LIM, SPEED_LIM);

        if (!c.powered || c.fault) begin
            lt = 0;
            rt = 0;
            left_speed = 0;
            right_speed = 0;
        end else begin
            left_angle = approach(left_angle, bound(int'(c.left_arm_target), 0, ANGLE_MAX),
                                  int'(servo_step));
            right_angle = approach(right_angle, bound(int'(c.right_arm_target), 0, ANGLE_MAX),
                                   int'(servo_step));
        end

        case (c.profile)
            PROF_SMOOTH: ramp = int'(step_smooth);
            PROF_NORMAL: ramp = int'(step_normal);
            default: ramp = int'(step_aggr);
        endcase
        left_speed = approach(left_speed, lt, ramp);
        right_speed = approach(right_speed, rt, ramp);

        {r.lf_duty, r.lb_duty} = duty_pair(left_speed);
        {r.rf_duty, r.rb_duty} = duty_pair(right_speed);
        r.left_us = 12'(SERVO_BASE_US + left_angle * SERVO_SPAN_US / ANGLE_MAX);
        r.right_us = 12'(SERVO_BASE_US + right_angle * SERVO_SPAN_US / ANGLE_MAX);
        r.left_now = 8'(left_speed);
        r.right_now = 8'(right_speed);
        return r;
    endfunction

    function automatic string fmt_result(t_drive_result r);
        return $sformatf("duty L %0d/%0d R %0d/%0d servo %0d/%0d speed %0d/%0d",
                         r.lf_duty, r.lb_duty, r.rf_duty, r.rb_duty,
                         r.left_us, r.right_us, r.left_now, r.right_now);
    endfunction

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Input driver: one item in flight on the port, refilled from the queue.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                drive_outputs_q.push_back(advance_drive(held_tick));
            end
            if (!i_in_valid || o_in_ready) begin
                if (tick_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    held_tick = tick_queue.pop_front();
                    i_in_valid <= 1'b1;
                    i_powered <= held_tick.powered;
                    i_fault <= held_tick.fault;
                    i_direction <= held_tick.direction;
                    i_speed_pct <= held_tick.speed_pct;
                    i_profile <= held_tick.profile;
                    i_direct_mode <= held_tick.direct_mode;
                    i_direct_left <= held_tick.direct_left;
                    i_direct_right <= held_tick.direct_right;
                    i_left_arm_target <= held_tick.left_arm_target;
                    i_right_arm_target <= held_tick.right_arm_target;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver stalls.
    always @(posedge i_clk) begin
        t_drive_result got;
        t_drive_result want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                got = '{o_left_fwd_duty, o_left_bwd_duty, o_right_fwd_duty,
                        o_right_bwd_duty, o_left_servo_us, o_right_servo_us,
                        o_left_speed_now, o_right_speed_now};
                if (drive_outputs_q.size() == 0) begin
                    error_count++;
                    if (error_count <= 10) begin
                        $display("unexpected result: %s", fmt_result(got));
                    end
                end else begin
                    want = drive_outputs_q.pop_front();
                    if (got !== want) begin
                        error_count++;
                        if (error_count <= 10) begin
                            $display("mismatch: expected %s, got %s",
                                     fmt_result(want), fmt_result(got));
                        end
                    end
                end
            end
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic queue_tick(logic pw, logic ft, logic [3:0] dir, int spd,
                              logic [1:0] prof, logic dm, int dl, int dr, int la, int ra);
        t_cmd c;
        c.powered = pw;
        c.fault = ft;
        c.direction = dir;
        c.speed_pct = 7'(spd);
        c.profile = prof;
        c.direct_mode = dm;
        c.direct_left = 8'(dl);
        c.direct_right = 8'(dr);
        c.left_arm_target = 8'(la);
        c.right_arm_target = 8'(ra);
        tick_queue.push_back(c);
    endtask

    function automatic t_cmd noise_cmd();
        t_cmd c;
        c.powered = 1'($urandom);
        c.fault = 1'($urandom);
        c.direction = 4'($urandom);
        c.speed_pct = 7'($urandom);
        c.profile = 2'($urandom);
        c.direct_mode = 1'($urandom);
        c.direct_left = 8'($urandom);
        c.direct_right = 8'($urandom);
        c.left_arm_target = 8'($urandom);
        c.right_arm_target = 8'($urandom);
        return c;
    endfunction

    function automatic t_cmd sane_cmd();
        t_cmd c;
        c.powered = 1'b1;
        c.fault = 1'b0;
        c.direction = 4'($urandom_range(8));
        c.speed_pct = 7'($urandom_range(SPEED_LIM));
        c.profile = 2'($urandom_range(2));
        c.direct_mode = ($urandom_range(3) == 0);
        c.direct_left = 8'(int'($urandom_range(200)) - 100);
        c.direct_right = 8'(int'($urandom_range(200)) - 100);
        c.left_arm_target = 8'($urandom_range(ANGLE_MAX));
        c.right_arm_target = 8'($urandom_range(ANGLE_MAX));
        return c;
    endfunction

    // Mostly steady commands held for runs of up to 30 items, with
    // the odd power drop or fault, plus some items of random bits.
    task automatic queue_random(int count);
        t_cmd base;
        t_cmd c;
        int queued;
        int len;
        queued = 0;
        while (queued < count) begin
            if ($urandom_range(99) < 80) begin
                base = sane_cmd();
                len = $urandom_range(1, 30);
                for (int k = 0; k < len && queued < count; k++) begin
                    if ($urandom_range(7) == 0) begin
                        base.left_arm_target = 8'($urandom_range(ANGLE_MAX));
                        base.speed_pct = 7'($urandom_range(SPEED_LIM));
                    end
                    c = base;
                    if ($urandom_range(19) == 0) begin
                        c.powered = 1'($urandom);
                        c.fault = ~c.powered | 1'($urandom);
                    end
                    tick_queue.push_back(c);
                    queued++;
                end
            end else begin
                tick_queue.push_back(noise_cmd());
                queued++;
            end
        end
    endtask

    // Called at a clock edge; returns at the edge where the write is taken.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_TURN_SCALE: turn_scale = val;
            CFG_SERVO_STEP: servo_step = val;
            CFG_RAMP_SMOOTH: step_smooth = val;
            CFG_RAMP_NORMAL: step_normal = val;
            CFG_RAMP_AGGR: step_aggr = val;
            default: ;
        endcase
    endtask

    task automatic program_regs(int ts, int ss, int rs, int rn, int ra);
        write_reg(CFG_TURN_SCALE, 8'(ts));
        write_reg(CFG_SERVO_STEP, 8'(ss));
        write_reg(CFG_RAMP_SMOOTH, 8'(rs));
        write_reg(CFG_RAMP_NORMAL, 8'(rn));
        write_reg(CFG_RAMP_AGGR, 8'(ra));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (tick_queue.size() != 0 || i_in_valid || drive_outputs_q.size() != 0);
        repeat (8) @(posedge i_clk);
    endtask

    initial begin
        #1_000_000;
        $display("[tank_drive_slew_controller_core] ERROR");
        $finish;
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed ticks at the reset register values.
        queue_tick(1, 0, DIR_HALT, 0, PROF_SMOOTH, 0, 0, 0, 90, 90);
        queue_tick(1, 0, DIR_FWD, 100, PROF_AGGR, 0, 0, 0, 180, 0);
        queue_tick(1, 0, DIR_FWD, 100, PROF_AGGR, 0, 0, 0, 180, 0);
        queue_tick(1, 0, DIR_BWD, 100, PROF_AGGR, 0, 0, 0, 0, 180);
        queue_tick(1, 0, DIR_SPIN_L, 20, PROF_NORMAL, 0, 0, 0, 45, 135);
        queue_tick(1, 0, DIR_SPIN_R, 127, PROF_AGGR, 0, 0, 0, 255, 200);
        queue_tick(1, 0, DIR_ARC_FL, 55, PROF_AGGR, 0, 0, 0, 181, 255);
        queue_tick(1, 0, DIR_ARC_FR, 55, PROF_NORMAL, 0, 0, 0, 0, 0);
        queue_tick(1, 0, DIR_ARC_BL, 77, 2'd3, 0, 0, 0, 10, 170);
        queue_tick(1, 0, DIR_ARC_BR, 77, 2'd3, 0, 0, 0, 10, 170);
        queue_tick(1, 0, 4'd9, 100, PROF_AGGR, 0, 0, 0, 90, 90);
        queue_tick(1, 0, 4'd15, 127, PROF_AGGR, 0, 0, 0, 90, 90);
        queue_tick(1, 0, DIR_HALT, 0, PROF_AGGR, 1, -128, 127, 90, 90);
        queue_tick(1, 0, DIR_HALT, 0, PROF_AGGR, 1, -128, 127, 90, 90);
        queue_tick(1, 0, DIR_HALT, 0, 2'd3, 1, 100, -100, 90, 90);
        queue_tick(1, 0, DIR_FWD, 100, PROF_SMOOTH, 1, 0, 0, 90, 90);
        queue_tick(0, 0, DIR_FWD, 100, PROF_AGGR, 0, 0, 0, 0, 0);
        queue_tick(1, 0, DIR_FWD, 127, PROF_NORMAL, 0, 0, 0, 0, 0);
        queue_tick(1, 1, DIR_FWD, 100, PROF_AGGR, 0, 0, 0, 180, 180);
        queue_tick(0, 1, DIR_BWD, 100, PROF_AGGR, 1, -100, -100, 180, 180);
        queue_tick(1, 0, DIR_SPIN_R, 0, PROF_AGGR, 0, 0, 0, 180, 180);
        queue_tick(1, 0, DIR_SPIN_L, 100, PROF_AGGR, 0, 0, 0, 180, 180);
        queue_random(130);

        for (int phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct = 0; stall_pct = 0; end
                1: begin send_idle_pct = 74; stall_pct = 0; end
                2: begin send_idle_pct = 0; stall_pct = 74; end
                default: begin send_idle_pct = 10; stall_pct = 10; end
            endcase
            if (phase != 0) begin
                wait_idle();
                case (phase)
                    1: program_regs(0, 0, 0, 0, 0);
                    2: program_regs(255, 255, 255, 255, 255);
                    3: program_regs(200, 180, 200, 200, 200);
                    4: program_regs(1, 1, 1, 1, 1);
                    default: program_regs($urandom_range(255), $urandom_range(ANGLE_MAX),
                                          $urandom_range(1, 50), $urandom_range(1, 50),
                                          $urandom_range(1, 50));
                endcase
                queue_random(165);
            end
        end

        wait_idle();
        if (error_count == 0 && drive_outputs_q.size() == 0) begin
            $display("[tank_drive_slew_controller_core] OK");
        end else begin
            $display("[tank_drive_slew_controller_core] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
